@@ src/sbcr_pkg.sv @@
// Shared types and constants for the sphere against box collision response block.
// No dependencies; imported by every module of the block.
package sbcr_pkg;

    // Data words and magnitudes
    localparam int unsigned QW   = 32;   // one signed Q-format word
    localparam int unsigned MAGW = 31;   // magnitude of an offset or distance in contact
    localparam int unsigned SQW  = 62;   // squared distance in contact

    // Queue between the front and back parts
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    // Division of the normal-velocity magnitude by five: floor(m / 5) is
    // (m * DIV5_MUL) >> DIV5_SHIFT for every m below 2^VMW.
    localparam int unsigned VMW         = 34;
    localparam int unsigned DIV5_SPLIT  = 17;
    localparam int unsigned DIV5_SHIFT  = 37;
    localparam int unsigned DIV5_MULW   = 35;
    localparam logic [DIV5_MULW-1:0] DIV5_MUL = 35'd27487790695;
    localparam int unsigned Q5W         = 32;  // width of floor(m / 5)
    localparam int unsigned KW          = 35;  // width of 1.2 times the magnitude
    localparam int unsigned SW          = 40;  // working width ahead of saturation

    typedef logic signed [QW-1:0] q_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MIN_X  = 3'd0,
        REG_MIN_Y  = 3'd1,
        REG_MIN_Z  = 3'd2,
        REG_MAX_X  = 3'd3,
        REG_MAX_Y  = 3'd4,
        REG_MAX_Z  = 3'd5,
        REG_RADIUS = 3'd6
    } reg_idx_t;

    // Box corners, axis 0 is x
    typedef struct packed {
        q_t [2:0] lo;
        q_t [2:0] hi;
    } box_t;

    // One classified item as it leaves the front part
    typedef struct packed {
        q_t [2:0]            pos;
        q_t [2:0]            vel;
        logic [2:0][MAGW-1:0] off_mag;
        logic [2:0]          off_neg;
        logic [SQW-1:0]      sq;
        logic                contact;
    } fr_item_t;

endpackage

@@ src/sbcr_front.sv @@
// Front part: clamps the center into the box, squares the offset and classifies contact.
// Depends on sbcr_pkg.
module sbcr_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sbcr_pkg::q_t [2:0]         in_pos,
    input  sbcr_pkg::q_t [2:0]         in_vel,
    input  sbcr_pkg::box_t             box,
    input  logic [sbcr_pkg::MAGW-1:0]  radius,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sbcr_pkg::fr_item_t         out_item
);
    import sbcr_pkg::*;

    logic                  en;
    logic                  v1_reg, v2_reg, v3_reg;
    q_t [2:0]              pos1_reg, vel1_reg, pos2_reg, vel2_reg;
    logic [2:0][MAGW-1:0]  mag1_reg, mag2_reg;
    logic [2:0]            neg1_reg, neg2_reg;
    logic                  far1_reg, far2_reg;
    logic [2:0][SQW-1:0]   sq2_reg;
    logic [SQW-1:0]        r2_reg;
    fr_item_t              item_reg;

    q_t                    lo_w   [3];
    q_t                    c_w    [3];
    logic signed [QW:0]    off_w  [3];
    logic [QW:0]           abs_w  [3];
    logic [2:0]            far_w;
    logic [SQW+1:0]        sum_w;

    // The whole front advances unless a finished item cannot enter the queue.
    assign en        = !v3_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v3_reg;
    assign out_item  = item_reg;

    // Clamp and offset per axis.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo_w[i]  = ($signed(in_pos[i]) < $signed(box.lo[i])) ? box.lo[i] : in_pos[i];
            c_w[i]   = ($signed(lo_w[i]) > $signed(box.hi[i])) ? box.hi[i] : lo_w[i];
            off_w[i] = $signed({in_pos[i][QW-1], in_pos[i]}) - $signed({c_w[i][QW-1], c_w[i]});
            abs_w[i] = off_w[i][QW] ? unsigned'(-off_w[i]) : unsigned'(off_w[i]);
            far_w[i] = abs_w[i][QW] | abs_w[i][QW-1];
        end
    end

    // Sum of squares for the contact test.
    assign sum_w = (SQW+2)'(sq2_reg[0]) + (SQW+2)'(sq2_reg[1]) + (SQW+2)'(sq2_reg[2]);

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            pos1_reg <= in_pos;
            vel1_reg <= in_vel;
            far1_reg <= |far_w;
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= abs_w[i][MAGW-1:0];
                neg1_reg[i] <= off_w[i][QW];
            end

            pos2_reg <= pos1_reg;
            vel2_reg <= vel1_reg;
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            far2_reg <= far1_reg;
            r2_reg   <= SQW'(radius) * SQW'(radius);
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= SQW'(mag1_reg[i]) * SQW'(mag1_reg[i]);
            end

            item_reg.pos     <= pos2_reg;
            item_reg.vel     <= vel2_reg;
            item_reg.off_mag <= mag2_reg;
            item_reg.off_neg <= neg2_reg;
            item_reg.sq      <= sum_w[SQW-1:0];
            item_reg.contact <= !far2_reg && (sum_w < {2'b00, r2_reg});
        end
    end

endmodule

@@ src/sbcr_fifo.sv @@
// Short queue that decouples the front part from the back part.
// Depends on sbcr_pkg.
module sbcr_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  sbcr_pkg::fr_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output sbcr_pkg::fr_item_t rd_item
);
    import sbcr_pkg::*;

    fr_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 push, pop;

    assign wr_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

@@ src/sbcr_back.sv @@
// Back part: square root, normal division, push-out, velocity response; one item a cycle if not stalled.
// Depends on sbcr_pkg.
module sbcr_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sbcr_pkg::fr_item_t         in_item,
    input  logic [sbcr_pkg::MAGW-1:0]  radius,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sbcr_pkg::q_t [2:0]         out_pos,
    output sbcr_pkg::q_t [2:0]         out_vel,
    output logic                       out_contact
);
    import sbcr_pkg::*;

    localparam int unsigned NSQ  = SQW / 2;          // square root steps
    localparam int unsigned NDIV = FRAC_BITS + 1;    // quotient bits of the normal
    localparam int unsigned DW   = MAGW + FRAC_BITS; // divider remainder
    localparam int unsigned NW   = FRAC_BITS + 2;    // signed normal component
    localparam int unsigned PW   = NW + QW;          // normal times a word
    localparam int unsigned DOTW = PW + 2;
    localparam int unsigned PPW  = (VMW - DIV5_SPLIT) + DIV5_MULW;
    localparam int unsigned PRW  = PPW + DIV5_SPLIT;
    localparam int unsigned NKW  = NW + KW + 1;
    localparam int unsigned NVLD = NSQ + NDIV + 8;
    localparam logic signed [NW-1:0] ONE_N = {2'b01, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic [SQW-1:0]  rad;
        logic [QW-1:0]   rem;
        logic [MAGW-1:0] root;
    } sq_st_t;

    typedef struct packed {
        logic [MAGW-1:0]        d;
        logic [MAGW-1:0]        depth;
        logic [2:0][DW-1:0]     rem;
        logic [2:0][NDIV-1:0]   q;
    } dv_st_t;

    typedef struct packed {
        q_t [2:0] pos;
        q_t [2:0] vel;
        logic     contact;
    } pv_t;

    // One step of the digit-by-digit square root: two radicand bits in, one root bit out.
    function automatic sq_st_t sq_step(input sq_st_t a);
        logic [QW+1:0] rem2;
        logic [QW+1:0] trial;
        sq_st_t        r;
        rem2  = {a.rem, a.rad[SQW-1 -: 2]};
        trial = {1'b0, a.root, 2'b01};
        r.rad = {a.rad[SQW-3:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = QW'(rem2 - trial);
            r.root = {a.root[MAGW-2:0], 1'b1};
        end else begin
            r.rem  = QW'(rem2);
            r.root = {a.root[MAGW-2:0], 1'b0};
        end
        return r;
    endfunction

    // One restoring division step for all three axes, quotient bit weight 2^j.
    function automatic dv_st_t dv_step(input dv_st_t a, input int unsigned j);
        logic [DW-1:0] sh;
        dv_st_t        r;
        r  = a;
        sh = DW'(a.d) << j;
        for (int i = 0; i < 3; i++) begin
            if (a.rem[i] >= sh) begin
                r.rem[i] = a.rem[i] - sh;
                r.q[i]   = {a.q[i][NDIV-2:0], 1'b1};
            end else begin
                r.q[i]   = {a.q[i][NDIV-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Saturate to a 32-bit signed word.
    function automatic q_t sat_q(input logic signed [SW-1:0] x);
        q_t r;
        if ((&x[SW-1:QW-1]) || !(|x[SW-1:QW-1])) begin
            r = x[QW-1:0];
        end else begin
            r = x[SW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        return r;
    endfunction

    logic en;
    logic [NVLD-1:0] vld_reg;

    // Square root chain
    sq_st_t   sst_reg   [NSQ];
    fr_item_t sitem_reg [NSQ];
    sq_st_t   snext     [NSQ];
    sq_st_t   sinit;

    // Divider chain
    dv_st_t   dst_reg   [NDIV];
    fr_item_t ditem_reg [NDIV];
    dv_st_t   dnext     [NDIV];
    dv_st_t   dinit;

    // Response stages
    logic signed [NW-1:0]   n_w  [3];
    logic signed [NW-1:0]   n0_reg [3], n1_reg [3], n2_reg [3], n3_reg [3], n4_reg [3],
                            n5_reg [3];
    logic [MAGW-1:0]        depth0_reg;
    pv_t                    pv0_reg, pv1_reg, pv2_reg, pv3_reg, pv4_reg, pv5_reg, pv6_reg;
    logic signed [PW-1:0]   pm1_reg [3], vm1_reg [3];
    logic signed [PW-1:0]   pmt_w [3];
    logic signed [SW-1:0]   psum_w [3];
    logic signed [DOTW-1:0] dot_w;
    q_t [2:0]               pos2_reg, pos3_reg, pos4_reg, pos5_reg, pos6_reg;
    logic signed [DOTW-1:0] dot2_reg;
    logic signed [DOTW-1:0] vn_w;
    logic [DOTW-1:0]        vabs_w;
    logic [VMW-1:0]         m3_reg, m4_reg;
    logic                   vneg3_reg, vneg4_reg, vneg5_reg, vneg6_reg;
    logic [PPW-1:0]         pph4_reg, ppl4_reg;
    logic [PRW-1:0]         prod_w;
    logic [KW-1:0]          k5_reg;
    logic signed [NKW-1:0]  nk6_reg [3];
    logic signed [NKW-1:0]  nkt_w [3];
    logic signed [SW-1:0]   vsum_w [3];
    q_t [2:0]               pos_out_reg, vel_out_reg;
    logic                   contact_out_reg;

    // The back advances whenever the output register is free or being taken.
    assign en          = !vld_reg[NVLD-1] || out_ready;
    assign in_ready    = en;
    assign out_valid   = vld_reg[NVLD-1];
    assign out_pos     = pos_out_reg;
    assign out_vel     = vel_out_reg;
    assign out_contact = contact_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NVLD-2:0], in_valid};
        end
    end

    // Square root of the squared distance.
    always_comb begin
        sinit.rad  = in_item.sq;
        sinit.rem  = '0;
        sinit.root = '0;
        snext[0]   = sq_step(sinit);
        for (int k = 1; k < NSQ; k++) begin
            snext[k] = sq_step(sst_reg[k-1]);
        end
    end

    // Normal division setup and steps.
    always_comb begin
        dinit.d     = sst_reg[NSQ-1].root;
        dinit.depth = radius - sst_reg[NSQ-1].root;
        for (int i = 0; i < 3; i++) begin
            dinit.rem[i] = DW'(sitem_reg[NSQ-1].off_mag[i]) << FRAC_BITS;
            dinit.q[i]   = '0;
        end
        dnext[0] = dv_step(dinit, FRAC_BITS);
        for (int t = 1; t < NDIV; t++) begin
            dnext[t] = dv_step(dst_reg[t-1], FRAC_BITS - t);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sst_reg[0]   <= snext[0];
            sitem_reg[0] <= in_item;
            for (int k = 1; k < NSQ; k++) begin
                sst_reg[k]   <= snext[k];
                sitem_reg[k] <= sitem_reg[k-1];
            end
            dst_reg[0]   <= dnext[0];
            ditem_reg[0] <= sitem_reg[NSQ-1];
            for (int t = 1; t < NDIV; t++) begin
                dst_reg[t]   <= dnext[t];
                ditem_reg[t] <= ditem_reg[t-1];
            end
        end
    end

    // Signed normal; a zero distance gives the up vector.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dst_reg[NDIV-1].d == '0) begin
                n_w[i] = (i == 1) ? ONE_N : '0;
            end else if (ditem_reg[NDIV-1].off_neg[i]) begin
                n_w[i] = -$signed({1'b0, dst_reg[NDIV-1].q[i]});
            end else begin
                n_w[i] = $signed({1'b0, dst_reg[NDIV-1].q[i]});
            end
        end
    end

    // Combinational push-out, dot product, normal velocity, divide by five and velocity correction.
    always_comb begin
        dot_w = '0;
        for (int i = 0; i < 3; i++) begin
            pmt_w[i]  = (pm1_reg[i] + $signed({{(PW-FRAC_BITS){1'b0}},
                        {FRAC_BITS{pm1_reg[i][PW-1]}}})) >>> FRAC_BITS;
            psum_w[i] = SW'(pv1_reg.pos[i]) + SW'(pmt_w[i]);
            dot_w     = dot_w + DOTW'(vm1_reg[i]);
        end
        vn_w   = (dot2_reg + $signed({{(DOTW-FRAC_BITS){1'b0}},
                 {FRAC_BITS{dot2_reg[DOTW-1]}}})) >>> FRAC_BITS;
        vabs_w = vn_w[DOTW-1] ? unsigned'(-vn_w) : unsigned'(vn_w);
        prod_w = (PRW'(pph4_reg) << DIV5_SPLIT) + PRW'(ppl4_reg);
        for (int i = 0; i < 3; i++) begin
            nkt_w[i]  = (nk6_reg[i] + $signed({{(NKW-FRAC_BITS){1'b0}},
                        {FRAC_BITS{nk6_reg[i][NKW-1]}}})) >>> FRAC_BITS;
            vsum_w[i] = SW'(pv6_reg.vel[i]) + SW'(nkt_w[i]);
        end
    end

    // Response pipeline.
    always_ff @(posedge aclk) begin
        if (en) begin
            // Normal
            n0_reg             <= n_w;
            depth0_reg         <= dst_reg[NDIV-1].depth;
            pv0_reg.pos        <= ditem_reg[NDIV-1].pos;
            pv0_reg.vel        <= ditem_reg[NDIV-1].vel;
            pv0_reg.contact    <= ditem_reg[NDIV-1].contact;

            // Products with depth and velocity
            for (int i = 0; i < 3; i++) begin
                pm1_reg[i] <= n0_reg[i] * $signed({1'b0, depth0_reg});
                vm1_reg[i] <= $signed(pv0_reg.vel[i]) * n0_reg[i];
            end
            n1_reg  <= n0_reg;
            pv1_reg <= pv0_reg;

            // Corrected position and dot product
            for (int i = 0; i < 3; i++) begin
                pos2_reg[i] <= sat_q(psum_w[i]);
            end
            dot2_reg <= dot_w;
            n2_reg   <= n1_reg;
            pv2_reg  <= pv1_reg;

            // Normal velocity magnitude and sign
            m3_reg    <= vabs_w[VMW-1:0];
            vneg3_reg <= vn_w[DOTW-1];
            n3_reg    <= n2_reg;
            pv3_reg   <= pv2_reg;
            pos3_reg  <= pos2_reg;

            // Partial products of the divide by five
            pph4_reg  <= PPW'(m3_reg[VMW-1:DIV5_SPLIT]) * PPW'(DIV5_MUL);
            ppl4_reg  <= PPW'(m3_reg[DIV5_SPLIT-1:0]) * PPW'(DIV5_MUL);
            m4_reg    <= m3_reg;
            vneg4_reg <= vneg3_reg;
            n4_reg    <= n3_reg;
            pv4_reg   <= pv3_reg;
            pos4_reg  <= pos3_reg;

            // 1.2 times the magnitude
            k5_reg    <= KW'(m4_reg) + KW'(prod_w[DIV5_SHIFT +: Q5W]);
            vneg5_reg <= vneg4_reg;
            n5_reg    <= n4_reg;
            pv5_reg   <= pv4_reg;
            pos5_reg  <= pos4_reg;

            // Velocity correction product
            for (int i = 0; i < 3; i++) begin
                nk6_reg[i] <= n5_reg[i] * $signed({1'b0, k5_reg});
            end
            vneg6_reg <= vneg5_reg;
            pv6_reg   <= pv5_reg;
            pos6_reg  <= pos5_reg;

            // Output register
            for (int i = 0; i < 3; i++) begin
                pos_out_reg[i] <= pv6_reg.contact ? pos6_reg[i] : pv6_reg.pos[i];
                vel_out_reg[i] <= (pv6_reg.contact && vneg6_reg) ? sat_q(vsum_w[i])
                                                                 : pv6_reg.vel[i];
            end
            contact_out_reg <= pv6_reg.contact;
        end
    end

endmodule

@@ src/sphere_box_collision_response.sv @@
// Top level of the sphere against box collision response block: register port and channels.
// Depends on sbcr_pkg, sbcr_front, sbcr_fifo and sbcr_back.
//
//   Channel   Direction  Handshake                 Content
//   s_        in         s_tvalid / s_tready       sphere position and velocity
//   m_        out        m_tvalid / m_tready       corrected position, velocity, contact
//   APB       in         psel, penable, pready     box corners and radius
//
// One item is accepted every cycle while no stall reaches the front. Each item passes three front
// stages, the queue, 31 square root steps, FRAC_BITS + 1 divider steps and eight response stages.
// Reset is synchronous and clears the valid bits, the queue pointers and the configuration registers.
// The front and back parts stall independently; a four-entry queue sits between them, and
// a stalled output holds the back part at once and the front part once the queue is full.
module sphere_box_collision_response #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Input channel
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    // Result channel
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [191:0]  m_tdata,   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, y, z
    output logic          m_tuser    // contact
);
    import sbcr_pkg::*;

    box_t              box_reg;
    logic [MAGW-1:0]   radius_reg;
    reg_idx_t          idx;
    logic              wr_en;

    q_t [2:0]          s_pos, s_vel, m_pos, m_vel;
    logic              q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    fr_item_t          q_wr_item, q_rd_item;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg    <= '0;
            radius_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MIN_X:  box_reg.lo[0] <= pwdata;
                REG_MIN_Y:  box_reg.lo[1] <= pwdata;
                REG_MIN_Z:  box_reg.lo[2] <= pwdata;
                REG_MAX_X:  box_reg.hi[0] <= pwdata;
                REG_MAX_Y:  box_reg.hi[1] <= pwdata;
                REG_MAX_Z:  box_reg.hi[2] <= pwdata;
                REG_RADIUS: radius_reg    <= pwdata[MAGW-1:0];
                default:    ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (idx)
            REG_MIN_X:  prdata = box_reg.lo[0];
            REG_MIN_Y:  prdata = box_reg.lo[1];
            REG_MIN_Z:  prdata = box_reg.lo[2];
            REG_MAX_X:  prdata = box_reg.hi[0];
            REG_MAX_Y:  prdata = box_reg.hi[1];
            REG_MAX_Z:  prdata = box_reg.hi[2];
            REG_RADIUS: prdata = {1'b0, radius_reg};
            default:    prdata = '0;
        endcase
    end

    // Field unpacking and packing.
    assign s_pos   = s_tdata[3*QW-1:0];
    assign s_vel   = s_tdata[6*QW-1:3*QW];
    assign m_tdata = {m_vel, m_pos};

    sbcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (s_pos),
        .in_vel    (s_vel),
        .box       (box_reg),
        .radius    (radius_reg),
        .out_valid (q_wr_valid),
        .out_ready (q_wr_ready),
        .out_item  (q_wr_item)
    );

    sbcr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    sbcr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_rd_valid),
        .in_ready    (q_rd_ready),
        .in_item     (q_rd_item),
        .radius      (radius_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pos     (m_pos),
        .out_vel     (m_vel),
        .out_contact (m_tuser)
    );

endmodule

@@ bench/tb_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sphere against box collision response block: watches both channels,
// predicts each result from its own copy of the box and radius, and counts mismatches.
// Depends on sbcr_pkg for the register index enum.
module tb_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending
);
    import sbcr_pkg::*;

    localparam int FB = 16;

    typedef struct packed {
        logic         contact;
        logic [191:0] data;
    } response_t;

    longint    lo_corner [3];
    longint    hi_corner [3];
    longint    radius;
    response_t expected_responses[$];

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Clamp to the box, test for penetration, push out and reflect the normal velocity.
    function automatic response_t collide(logic [191:0] din);
        longint p[3], v[3], off[3], n[3];
        longint c, d, depth, dot, vn, k;
        longint unsigned sq;
        logic far;
        response_t r;
        far = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(din[32*i +: 32]));
            v[i] = longint'($signed(din[96 + 32*i +: 32]));
            c = (p[i] < lo_corner[i]) ? lo_corner[i] : p[i];
            if (c > hi_corner[i]) c = hi_corner[i];
            off[i] = p[i] - c;
            if (off[i] >= 64'sd2147483648 || off[i] <= -64'sd2147483648) far = 1;
        end
        if (!far)
            for (int i = 0; i < 3; i++) sq += longint'(off[i] * off[i]);
        r.data = din;
        r.contact = 0;
        if (far || sq >= longint'(radius * radius)) return r;
        d = root_floor(sq);
        depth = radius - d;
        if (d == 0) begin
            n[0] = 0;
            n[1] = 64'sd1 << FB;
            n[2] = 0;
        end else begin
            for (int i = 0; i < 3; i++) n[i] = (off[i] * (64'sd1 << FB)) / d;
        end
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            r.data[32*i +: 32] = clip32(p[i] + (n[i] * depth) / (64'sd1 << FB));
            dot += v[i] * n[i];
        end
        vn = dot / (64'sd1 << FB);
        if (vn < 0) begin
            k = (vn * 6) / 5;
            for (int i = 0; i < 3; i++)
                r.data[96 + 32*i +: 32] = clip32(v[i] - (n[i] * k) / (64'sd1 << FB));
        end
        r.contact = 1;
        return r;
    endfunction

    assign pending = expected_responses.size();

    always @(posedge aclk) begin
        response_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                lo_corner[i] <= 0;
                hi_corner[i] <= 0;
            end
            radius <= 0;
            fail_count <= 0;
            expected_responses.delete();
        end else begin
            // Shadow register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_MIN_X:  lo_corner[0] <= longint'($signed(pwdata));
                    REG_MIN_Y:  lo_corner[1] <= longint'($signed(pwdata));
                    REG_MIN_Z:  lo_corner[2] <= longint'($signed(pwdata));
                    REG_MAX_X:  hi_corner[0] <= longint'($signed(pwdata));
                    REG_MAX_Y:  hi_corner[1] <= longint'($signed(pwdata));
                    REG_MAX_Z:  hi_corner[2] <= longint'($signed(pwdata));
                    REG_RADIUS: radius <= longint'(pwdata[30:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_responses.push_back(collide(s_tdata));
            // Compare each accepted result with the oldest expectation.
            if (m_tvalid && m_tready) begin
                if (expected_responses.size() == 0) begin
                    $display("%0t: unexpected result %h contact %b", $time, m_tdata, m_tuser);
                    errs++;
                end else begin
                    want = expected_responses.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_tdata[32*f +: 32] !== want.data[32*f +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     want.data[32*f +: 32], m_tdata[32*f +: 32]);
                            errs++;
                        end
                    if (m_tuser !== want.contact) begin
                        $display("%0t: contact expected %b actual %b", $time,
                                 want.contact, m_tuser);
                        errs++;
                    end
                end
            end
            // One update of the count per cycle, however many fields differ.
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, register writes, sphere stimulus with random gaps, receiver stalls.
// Depends on sbcr_pkg, sphere_box_collision_response and tb_checker.
module tb_top;
    import sbcr_pkg::*;

    localparam int LATENCY = 44 + 16;

    logic         aclk, aresetn;
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [31:0]  pwdata, prdata;
    logic         s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
    logic [191:0] s_tdata, m_tdata;
    int           fail_count, pending;
    int           burst_left;

    sphere_box_collision_response dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    tb_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Receiver stalls: runs of steady ready alternate with runs of random stalls.
    initial begin
        m_tready = 0;
        forever begin
            int mode, run;
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(posedge aclk);
                m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
            end
        end
    end

    initial begin
        #20000000;
        $display("tb_top failed");
        $finish;
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz, rad);
        write_reg(REG_MIN_X, lx); write_reg(REG_MIN_Y, ly); write_reg(REG_MIN_Z, lz);
        write_reg(REG_MAX_X, hx); write_reg(REG_MAX_Y, hy); write_reg(REG_MAX_Z, hz);
        write_reg(REG_RADIUS, rad);
    endtask

    // Send one item; bursts of random length alternate with random gaps.
    task automatic send_sphere(logic [191:0] item);
        if (burst_left == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(posedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid right after the last accepting edge so no item goes in twice.
    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // A coordinate near the box: mostly small, sometimes any value.
    function automatic logic [31:0] coord(int span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] speed();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h80000000 | $urandom_range(0, 3);
            2: return 32'h7fffffff - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
    endfunction

    initial begin
        logic [191:0] item;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; burst_left = 0;
        aresetn = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // Directed: reset box with zero radius, then a unit box with radius 0.5.
        send_sphere('0);
        send_sphere({6{32'h80000000}});
        send_sphere({6{32'h7fffffff}});
        drain();
        set_box(32'hffff0000, 32'hffff0000, 32'hffff0000,
                32'h00010000, 32'h00010000, 32'h00010000, 32'h00008000);
        send_sphere('0);                                             // center inside
        send_sphere({32'hfffc0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00014000}); // moving along the face
        send_sphere({32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00014000, 32'h0}); // moving away
        send_sphere({32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00011000});
        send_sphere({32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h00011000});
        send_sphere({32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h00010000});
        send_sphere({32'h0, 32'h0, 32'h0, 32'h00004000, 32'h0, 32'h00010000});
        drain();
        // Inverted box and maximum radius at the extremes.
        set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_sphere({6{32'h80000000}});
        send_sphere({6{32'h7fffffff}});
        send_sphere('0);
        send_sphere({32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     32'h80000000, 32'h7fffffff, 32'h80000000});
        drain();

        // Random phases with fresh boxes.
        for (int ph = 0; ph < 10; ph++) begin
            int span;
            logic [31:0] rad;
            span = (ph % 3 == 0) ? 32'h00400000 : 32'h00040000;
            rad = (ph == 9) ? 32'h7fffffff : $urandom_range(0, 32'h00030000);
            if (ph == 8)
                set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                set_box(coord(span / 4) - span / 4, coord(span / 4) - span / 4,
                        coord(span / 4) - span / 4, coord(span / 4) + span / 4,
                        coord(span / 4) + span / 4, coord(span / 4) + span / 4, rad);
            for (int i = 0; i < 125; i++) begin
                item = {speed(), speed(), speed(), coord(span), coord(span), coord(span)};
                send_sphere(item);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/sbcr_pkg.sv
src/sbcr_front.sv
src/sbcr_fifo.sv
src/sbcr_back.sv
src/sphere_box_collision_response.sv
bench/tb_checker.sv
bench/tb_top.sv
